@@ sv/tpbp_pkg.sv @@
// Shared types and constants for the tracking packet block parser.
// Used by tpbp_parser and tracking_packet_block_parser_top; no dependencies.
package tpbp_pkg;

    localparam int MAX_PACKET_BYTES = 1024;
    localparam int PKT_CNT_W        = $clog2(MAX_PACKET_BYTES + 1);

    typedef enum logic [3:0] {
        PH_ID,
        PH_VER,
        PH_SIZE,
        PH_COUNT,
        BK_ID,
        BK_VER,
        BK_SIZE,
        FI_TIME,
        FI_FOUND,
        POSE,
        BS_COUNT,
        BS_WEIGHT,
        EYES,
        MK_COUNT,
        MK_COORD,
        DONE
    } t_phase;

    // Result kinds
    localparam logic [4:0] KIND_TIMESTAMP = 5'd0;
    localparam logic [4:0] KIND_FOUND     = 5'd1;
    localparam logic [4:0] KIND_ROT_X     = 5'd2;
    localparam logic [4:0] KIND_WEIGHT    = 5'd9;
    localparam logic [4:0] KIND_EYE_FIRST = 5'd10;
    localparam logic [4:0] KIND_MARKER_X  = 5'd14;
    localparam logic [4:0] KIND_VERSION   = 5'd17;
    localparam logic [4:0] KIND_END       = 5'd18;
    localparam logic [4:0] KIND_WCOUNT    = 5'd19;
    localparam logic [4:0] KIND_MCOUNT    = 5'd20;

    // Block ids
    localparam logic [15:0] ID_FRAME   = 16'd101;
    localparam logic [15:0] ID_POSE    = 16'd102;
    localparam logic [15:0] ID_BLEND   = 16'd103;
    localparam logic [15:0] ID_EYES    = 16'd104;
    localparam logic [15:0] ID_MARKERS = 16'd105;

    // Body type held in the subfield register during a block header
    localparam logic [2:0] BODY_NONE    = 3'd0;
    localparam logic [2:0] BODY_FRAME   = 3'd1;
    localparam logic [2:0] BODY_POSE    = 3'd2;
    localparam logic [2:0] BODY_BLEND   = 3'd3;
    localparam logic [2:0] BODY_EYES    = 3'd4;
    localparam logic [2:0] BODY_MARKERS = 3'd5;

    localparam logic [2:0] POSE_LAST   = 3'd6;
    localparam logic [2:0] EYES_LAST   = 3'd3;
    localparam logic [2:0] COORD_LAST  = 3'd2;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [9:0]  element_index;
        logic [63:0] field_value;
        logic        version_mismatch;
        logic        packet_status;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Field length in bytes, minus one
    function automatic logic [2:0] phase_len_m1(input t_phase ph);
        logic [2:0] len;
        unique case (ph) inside
            PH_ID, PH_VER, PH_COUNT, BK_ID, BK_VER, MK_COUNT: len = 3'd1;
            PH_SIZE, BK_SIZE, POSE, BS_COUNT, BS_WEIGHT,
            EYES, MK_COORD:                                   len = 3'd3;
            FI_TIME:                                          len = 3'd7;
            FI_FOUND, DONE:                                   len = 3'd0;
            default:                                          len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

@@ sv/tpbp_parser.sv @@
// Byte-wise packet parser: field assembly, phase sequencing, result forming.
// Depends on tpbp_pkg.
module tpbp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_packet,
    input  logic [15:0]           i_ref_version,
    output tpbp_pkg::t_push       o_push
);
    import tpbp_pkg::*;

    t_phase                 r_phase, n_phase, w_phase_taken;
    logic [2:0]             r_bif, n_bif;
    logic [63:0]            r_asm, n_asm;
    logic [15:0]            r_blocks, n_blocks;
    logic [31:0]            r_elems, n_elems;
    logic [9:0]             r_list, n_list;
    logic [2:0]             r_sub, n_sub;
    logic [PKT_CNT_W-1:0]   r_pkt_cnt, n_pkt_cnt;
    logic                   r_ver_chk, n_ver_chk;

    logic                   w_in_window;
    logic                   w_field_done;
    logic [63:0]            w_value;
    logic [15:0]            w_blocks_dec;

    assign w_in_window  = r_pkt_cnt < PKT_CNT_W'(MAX_PACKET_BYTES);
    assign w_field_done = i_take && w_in_window && (r_phase != DONE)
                          && (r_bif == phase_len_m1(r_phase));
    assign w_blocks_dec = r_blocks - 16'd1;

    // Drop the new byte into its lane
    always_comb begin
        w_value = r_asm;
        for (int i = 0; i < 8; i++) begin
            if (r_bif == 3'(i)) begin
                w_value[8*i +: 8] = i_data_byte;
            end
        end
    end

    // Next state
    always_comb begin
        n_bif     = r_bif;
        n_asm     = r_asm;
        n_blocks  = r_blocks;
        n_elems   = r_elems;
        n_list    = r_list;
        n_sub     = r_sub;
        n_pkt_cnt = r_pkt_cnt;
        n_ver_chk = r_ver_chk;
        w_phase_taken = r_phase;

        if (i_take && w_in_window) begin
            n_pkt_cnt = r_pkt_cnt + PKT_CNT_W'(1);
            if (r_phase != DONE) begin
                if (w_field_done) begin
                    n_bif = 3'd0;
                    n_asm = 64'd0;
                end else begin
                    n_bif = r_bif + 3'd1;
                    n_asm = w_value;
                end
            end
        end

        if (w_field_done) begin
            unique case (r_phase)
                PH_ID:   w_phase_taken = PH_VER;
                PH_VER: begin
                    n_ver_chk     = 1'b1;
                    w_phase_taken = PH_SIZE;
                end
                PH_SIZE: w_phase_taken = PH_COUNT;
                PH_COUNT: begin
                    n_blocks      = w_value[15:0];
                    w_phase_taken = (w_value[15:0] == 16'd0) ? DONE : BK_ID;
                end
                BK_ID: begin
                    case (w_value[15:0])
                        ID_FRAME:   n_sub = BODY_FRAME;
                        ID_POSE:    n_sub = BODY_POSE;
                        ID_BLEND:   n_sub = BODY_BLEND;
                        ID_EYES:    n_sub = BODY_EYES;
                        ID_MARKERS: n_sub = BODY_MARKERS;
                        default:    n_sub = BODY_NONE;
                    endcase
                    w_phase_taken = BK_VER;
                end
                BK_VER: w_phase_taken = BK_SIZE;
                BK_SIZE: begin
                    n_sub = 3'd0;
                    case (r_sub)
                        BODY_FRAME:   w_phase_taken = FI_TIME;
                        BODY_POSE:    w_phase_taken = POSE;
                        BODY_BLEND:   w_phase_taken = BS_COUNT;
                        BODY_EYES:    w_phase_taken = EYES;
                        BODY_MARKERS: w_phase_taken = MK_COUNT;
                        default: begin
                            // unknown id: no body, close the block
                            n_blocks      = w_blocks_dec;
                            w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                        end
                    endcase
                end
                FI_TIME: w_phase_taken = FI_FOUND;
                FI_FOUND: begin
                    n_blocks      = w_blocks_dec;
                    w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                end
                POSE: begin
                    n_sub = r_sub + 3'd1;
                    if (r_sub == POSE_LAST) begin
                        n_sub         = 3'd0;
                        n_blocks      = w_blocks_dec;
                        w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                    end
                end
                BS_COUNT: begin
                    n_elems = w_value[31:0];
                    n_list  = 10'd0;
                    if (w_value[31:0] == 32'd0) begin
                        n_blocks      = w_blocks_dec;
                        w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                    end else begin
                        w_phase_taken = BS_WEIGHT;
                    end
                end
                BS_WEIGHT: begin
                    n_list  = r_list + 10'd1;
                    n_elems = r_elems - 32'd1;
                    if (r_elems == 32'd1) begin
                        n_blocks      = w_blocks_dec;
                        w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                    end
                end
                EYES: begin
                    n_sub = r_sub + 3'd1;
                    if (r_sub == EYES_LAST) begin
                        n_sub         = 3'd0;
                        n_blocks      = w_blocks_dec;
                        w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                    end
                end
                MK_COUNT: begin
                    n_elems = {16'd0, w_value[15:0]};
                    n_list  = 10'd0;
                    n_sub   = 3'd0;
                    if (w_value[15:0] == 16'd0) begin
                        n_blocks      = w_blocks_dec;
                        w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                    end else begin
                        w_phase_taken = MK_COORD;
                    end
                end
                MK_COORD: begin
                    n_sub = r_sub + 3'd1;
                    if (r_sub == COORD_LAST) begin
                        n_sub   = 3'd0;
                        n_list  = r_list + 10'd1;
                        n_elems = r_elems - 32'd1;
                        if (r_elems == 32'd1) begin
                            n_blocks      = w_blocks_dec;
                            w_phase_taken = (w_blocks_dec == 16'd0) ? DONE : BK_ID;
                        end
                    end
                end
                DONE: w_phase_taken = DONE;
                default: w_phase_taken = r_phase;
            endcase
        end

        n_phase = w_phase_taken;
        // End mark: back to the packet header, keep the version flag
        if (i_take && i_end_of_packet) begin
            n_phase   = PH_ID;
            n_bif     = 3'd0;
            n_asm     = 64'd0;
            n_blocks  = 16'd0;
            n_elems   = 32'd0;
            n_list    = 10'd0;
            n_sub     = 3'd0;
            n_pkt_cnt = '0;
        end
    end

    // Results
    always_comb begin
        t_result fres;
        t_result eres;
        logic    emit;

        fres  = '0;
        emit  = 1'b0;
        fres.field_value = w_value;
        unique case (r_phase) inside
            PH_VER: begin
                emit = 1'b1;
                fres.field_kind       = KIND_VERSION;
                fres.version_mismatch = !r_ver_chk && (w_value[15:0] != i_ref_version);
            end
            FI_TIME: begin
                emit = 1'b1;
                fres.field_kind = KIND_TIMESTAMP;
            end
            FI_FOUND: begin
                emit = 1'b1;
                fres.field_kind = KIND_FOUND;
            end
            POSE: begin
                emit = 1'b1;
                fres.field_kind = KIND_ROT_X + {2'b00, r_sub};
            end
            BS_COUNT: begin
                emit = 1'b1;
                fres.field_kind = KIND_WCOUNT;
            end
            BS_WEIGHT: begin
                emit = 1'b1;
                fres.field_kind    = KIND_WEIGHT;
                fres.element_index = r_list;
            end
            EYES: begin
                emit = 1'b1;
                fres.field_kind = KIND_EYE_FIRST + {2'b00, r_sub};
            end
            MK_COUNT: begin
                emit = 1'b1;
                fres.field_kind = KIND_MCOUNT;
            end
            MK_COORD: begin
                emit = 1'b1;
                fres.field_kind    = KIND_MARKER_X + {2'b00, r_sub};
                fres.element_index = r_list;
            end
            PH_ID, PH_SIZE, PH_COUNT, BK_ID, BK_VER, BK_SIZE, DONE: emit = 1'b0;
            default: emit = 1'b0;
        endcase
        emit = emit && w_field_done;

        eres               = '0;
        eres.field_kind    = KIND_END;
        eres.packet_status = (w_phase_taken != DONE);
        eres.last_of_run   = 1'b1;

        fres.last_of_run = !(i_take && i_end_of_packet);

        o_push = '0;
        if (emit && i_take && i_end_of_packet) begin
            o_push.count = 2'd2;
            o_push.res0  = fres;
            o_push.res1  = eres;
        end else if (emit) begin
            o_push.count = 2'd1;
            o_push.res0  = fres;
        end else if (i_take && i_end_of_packet) begin
            o_push.count = 2'd1;
            o_push.res0  = eres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_bif     <= 3'd0;
            r_asm     <= 64'd0;
            r_blocks  <= 16'd0;
            r_elems   <= 32'd0;
            r_list    <= 10'd0;
            r_sub     <= 3'd0;
            r_pkt_cnt <= '0;
            r_ver_chk <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_bif     <= n_bif;
            r_asm     <= n_asm;
            r_blocks  <= n_blocks;
            r_elems   <= n_elems;
            r_list    <= n_list;
            r_sub     <= n_sub;
            r_pkt_cnt <= n_pkt_cnt;
            r_ver_chk <= n_ver_chk;
        end
    end

endmodule

@@ sv/tracking_packet_block_parser_top.sv @@
// Top level of the tracking packet block parser: handshakes, version register,
// four-entry result queue. Depends on tpbp_pkg and tpbp_parser.
// A result is written into the result queue and offered from its head.
// Throughput: one byte per cycle while input is not stalled; a byte carrying
// the end mark after a field yields two results. Input stalls while the
// result queue has fewer than two free entries.
// Reset (synchronous, active low): parser at packet header, queue empty,
// reference version 1, version check armed.
module tracking_packet_block_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_field_kind,
    output logic [9:0]  o_element_index,
    output logic [63:0] o_field_value,
    output logic        o_version_mismatch,
    output logic        o_packet_status,
    output logic        o_last_of_run
);
    import tpbp_pkg::*;

    logic [15:0] r_ref_version;
    t_result     r_q [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt, n_cnt;
    t_push       w_push;
    logic        w_take, w_pop;
    t_result     w_head;

    assign o_ready = (r_cnt <= 3'd2);
    assign w_take  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    tpbp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_ref_version   (r_ref_version),
        .o_push          (w_push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_version <= 16'd1;
        end else if (i_cfg_we) begin
            r_ref_version <= i_cfg_wdata;
        end
    end

    assign n_cnt = r_cnt + {1'b0, w_push.count} - {2'b00, w_pop};

    // Queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + w_push.count;
            r_rp  <= r_rp + {1'b0, w_pop};
            r_cnt <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push.count != 2'd0) begin
            r_q[r_wp] <= w_push.res0;
        end
        if (w_push.count == 2'd2) begin
            r_q[r_wp + 2'd1] <= w_push.res1;
        end
    end

    assign w_head             = r_q[r_rp];
    assign o_valid            = (r_cnt != 3'd0);
    assign o_field_kind       = w_head.field_kind;
    assign o_element_index    = w_head.element_index;
    assign o_field_value      = w_head.field_value;
    assign o_version_mismatch = w_head.version_mismatch;
    assign o_packet_status    = w_head.packet_status;
    assign o_last_of_run      = w_head.last_of_run;

endmodule
